FILE: hdl/arxm_pkg.sv
package arxm_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned NumWords   = 8;
  localparam int unsigned NumStages  = 4;
  localparam int unsigned RoundsDflt = 3;
  localparam int unsigned RotW       = 6;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumWords-1:0] blk_t;

  // Left rotation amounts per stage: first and second target word
  localparam logic [NumStages-1:0][1:0][RotW-1:0] RotAmt = '{
    '{6'd47, 6'd16},
    '{6'd45, 6'd18},
    '{6'd43, 6'd20},
    '{6'd41, 6'd22}
  };

  function automatic word_t rotl(input word_t x, input logic [RotW-1:0] r);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << r;
    return dbl[2*WordW-1 -: WordW];
  endfunction

endpackage

FILE: hdl/arxm_in_if.sv
interface arxm_in_if import arxm_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t in_w0;
  word_t in_w1;
  word_t in_w2;
  word_t in_w3;
  word_t in_w4;
  word_t in_w5;
  word_t in_w6;
  word_t in_w7;

  modport source (output valid, in_w0, in_w1, in_w2, in_w3, in_w4, in_w5, in_w6, in_w7,
                  input ready);
  modport sink   (input valid, in_w0, in_w1, in_w2, in_w3, in_w4, in_w5, in_w6, in_w7,
                  output ready);
endinterface

FILE: hdl/arxm_out_if.sv
interface arxm_out_if import arxm_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t out_w0;
  word_t out_w1;
  word_t out_w2;
  word_t out_w3;
  word_t out_w4;
  word_t out_w5;
  word_t out_w6;
  word_t out_w7;

  modport source (output valid, out_w0, out_w1, out_w2, out_w3, out_w4, out_w5, out_w6,
                  out_w7, input ready);
  modport sink   (input valid, out_w0, out_w1, out_w2, out_w3, out_w4, out_w5, out_w6,
                  out_w7, output ready);
endinterface

FILE: hdl/arx_512bit_mixing_permutation.sv
// 512-bit ARX mixing permutation. Each block of eight 64-bit words passes through
// ROUNDS*4 register stages, one per word-pair mix (xor, crosswise 64-bit add, rotate).
// A block is written into the first stage at the edge that accepts it and then moves
// through the stage registers in order to the output. With the output ready, one block
// per cycle is accepted and delivered in steady state. The 64-bit adder pair of one
// stage sets the clock period. out_o.ready reaches in_i.ready through a short
// combinational chain of one gate per stage. A stage holds its block while the output
// is stalled; empty stages still take new blocks, so bubbles close up. No state is kept
// between blocks.
module arx_512bit_mixing_permutation import arxm_pkg::*; #(
  parameter int unsigned ROUNDS = RoundsDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arxm_in_if.sink    in_i,
  arxm_out_if.source out_o
);

  localparam int unsigned NumPipe = ROUNDS * NumStages;

  logic [NumPipe:0] valid_c;
  logic [NumPipe:0] ready_c;
  blk_t             blk_c [NumPipe+1];

  // Input side
  assign valid_c[0] = in_i.valid;
  assign in_i.ready = ready_c[0];
  assign blk_c[0]   = {in_i.in_w7, in_i.in_w6, in_i.in_w5, in_i.in_w4,
                       in_i.in_w3, in_i.in_w2, in_i.in_w1, in_i.in_w0};

  // Stage chain
  for (genvar k = 0; k < NumPipe; k++) begin : g_stage
    arxm_stage #(
      .STAGE_SEL(k % NumStages)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[k]),
      .blk_i  (blk_c[k]),
      .ready_o(ready_c[k]),
      .valid_o(valid_c[k+1]),
      .blk_o  (blk_c[k+1]),
      .ready_i(ready_c[k+1])
    );
  end

  // Output side
  assign out_o.valid      = valid_c[NumPipe];
  assign ready_c[NumPipe] = out_o.ready;
  assign out_o.out_w0     = blk_c[NumPipe][0];
  assign out_o.out_w1     = blk_c[NumPipe][1];
  assign out_o.out_w2     = blk_c[NumPipe][2];
  assign out_o.out_w3     = blk_c[NumPipe][3];
  assign out_o.out_w4     = blk_c[NumPipe][4];
  assign out_o.out_w5     = blk_c[NumPipe][5];
  assign out_o.out_w6     = blk_c[NumPipe][6];
  assign out_o.out_w7     = blk_c[NumPipe][7];

endmodule

FILE: hdl/arxm_stage.sv
// One mixing stage: xor, crosswise add and rotate on one word pair, then a register.
module arxm_stage import arxm_pkg::*; #(
  parameter int unsigned STAGE_SEL = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  blk_t blk_i,
  output logic ready_o,
  output logic valid_o,
  output blk_t blk_o,
  input  logic ready_i
);

  localparam int unsigned TIdx = ((STAGE_SEL + 1) * 2) % NumWords;
  localparam int unsigned PIdx = (STAGE_SEL * 2) % NumWords;

  logic  valid_q;
  blk_t  blk_q, blk_d;
  word_t sum_a, sum_b;
  logic  load;

  // Register takes a new block when empty or when downstream drains it
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Mix the target pair with the previous pair
  always_comb begin
    sum_a = (blk_i[TIdx] ^ blk_i[PIdx]) + blk_i[PIdx+1];
    sum_b = (blk_i[TIdx+1] ^ blk_i[PIdx+1]) + blk_i[PIdx];
    blk_d = blk_i;
    blk_d[TIdx]   = rotl(sum_a, RotAmt[STAGE_SEL][0]);
    blk_d[TIdx+1] = rotl(sum_b, RotAmt[STAGE_SEL][1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

`ifndef SYNTH
  a_stall_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q)
    else $error("stalled stage lost its word");
  a_stall_keeps_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> $stable(blk_q))
    else $error("stalled stage data changed");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("accepted word not held");
  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |-> !load)
    else $error("stage overwritten while full");
`endif

endmodule

FILE: tb/arxm_perm_checker.sv
`timescale 1ns / 1ps

// Watches both word channels, predicts each permuted block and compares it
// against what the block delivers, in order.
module arxm_perm_checker import arxm_pkg::*; #(
  parameter int unsigned ROUNDS = RoundsDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arxm_in_if          word_in,
  arxm_out_if         word_out,
  output int unsigned mismatch_cnt_o,
  output int unsigned blocks_pending_o
);

  // Keeps the log readable when the block is badly broken
  localparam int unsigned MaxReports = 64;

  blk_t        expected_q[$];
  int unsigned mismatches = 0;

  // Left rotation per stage: first and second target word
  function automatic int unsigned stage_rot(input int unsigned stage, input bit second);
    case (stage)
      0:       return second ? 41 : 22;
      1:       return second ? 43 : 20;
      2:       return second ? 45 : 18;
      default: return second ? 47 : 16;
    endcase
  endfunction

  function automatic word_t rot_left(input word_t x, input int unsigned r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  // ROUNDS rounds of four pair mixes: xor with previous pair, crosswise add, rotate
  function automatic blk_t permute_block(input blk_t src);
    blk_t        w;
    word_t       a;
    word_t       b;
    int unsigned tgt;
    int unsigned prv;
    w = src;
    for (int unsigned rnd = 0; rnd < ROUNDS; rnd++) begin
      for (int unsigned s = 0; s < NumStages; s++) begin
        tgt = ((s + 1) * 2) % NumWords;
        prv = s * 2;
        a = (w[tgt] ^ w[prv]) + w[prv+1];
        b = (w[tgt+1] ^ w[prv+1]) + w[prv];
        w[tgt]   = rot_left(a, stage_rot(s, 1'b0));
        w[tgt+1] = rot_left(b, stage_rot(s, 1'b1));
      end
    end
    return w;
  endfunction

  // Compare delivered words first, then record the newly accepted block
  always @(posedge clk_i) begin
    blk_t got;
    blk_t want;
    if (rst_ni) begin
      if (word_out.valid && word_out.ready) begin
        got = {word_out.out_w7, word_out.out_w6, word_out.out_w5, word_out.out_w4,
               word_out.out_w3, word_out.out_w2, word_out.out_w1, word_out.out_w0};
        if (expected_q.size() == 0) begin
          if (mismatches < MaxReports) $error("output word with no block pending: %h", got);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < NumWords; i++) begin
            if (got[i] !== want[i]) begin
              if (mismatches < MaxReports) begin
                $error("out_w%0d: expected %h, actual %h", i, want[i], got[i]);
              end
              mismatches++;
            end
          end
        end
      end
      if (word_in.valid && word_in.ready) begin
        expected_q.push_back(permute_block({word_in.in_w7, word_in.in_w6, word_in.in_w5,
                                            word_in.in_w4, word_in.in_w3, word_in.in_w2,
                                            word_in.in_w1, word_in.in_w0}));
      end
    end
    mismatch_cnt_o   <= mismatches;
    blocks_pending_o <= expected_q.size();
  end

endmodule

FILE: tb/arx_512bit_mixing_permutation_test.sv
`timescale 1ns / 1ps

module arx_512bit_mixing_permutation_test;
  import arxm_pkg::*;

  localparam int unsigned Rounds     = RoundsDflt;
  localparam int unsigned PipeDepth  = Rounds * NumStages;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned StallLimit = 2000;

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_cnt;
  int unsigned blocks_pending;
  int unsigned quiet_cycles = 0;

  // Idle/stall odds in percent, plus a request for one long receiver hold-off
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;

  arxm_in_if  word_in ();
  arxm_out_if word_out ();

  arx_512bit_mixing_permutation #(
    .ROUNDS (Rounds)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (word_in),
    .out_o  (word_out)
  );

  arxm_perm_checker #(
    .ROUNDS (Rounds)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .word_in          (word_in),
    .word_out         (word_out),
    .mismatch_cnt_o   (mismatch_cnt),
    .blocks_pending_o (blocks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    word_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        word_out.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        word_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too long without a word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** arx_512bit_mixing_permutation: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_words(input blk_t b);
    word_in.in_w0 <= b[0];
    word_in.in_w1 <= b[1];
    word_in.in_w2 <= b[2];
    word_in.in_w3 <= b[3];
    word_in.in_w4 <= b[4];
    word_in.in_w5 <= b[5];
    word_in.in_w6 <= b[6];
    word_in.in_w7 <= b[7];
  endtask

  // Offer one block after a random gap; returns at the edge it is taken
  task automatic send_block(input blk_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      word_in.valid <= 1'b0;
      @(posedge clk);
    end
    word_in.valid <= 1'b1;
    drive_words(b);
    @(posedge clk);
    while (!word_in.ready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted block has come out
  task automatic drain_results();
    word_in.valid <= 1'b0;
    do @(posedge clk); while (blocks_pending != 0);
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly dense random blocks, some counter-mode blocks, some sparse ones
  function automatic blk_t rand_block();
    blk_t b;
    b = '0;
    case ($urandom_range(7))
      0: begin
        b[0] = rand_word();
        b[1] = 64'd1;
      end
      1: begin
        for (int i = 0; i < NumWords; i++) begin
          case ($urandom_range(2))
            0:       b[i] = '0;
            1:       b[i] = '1;
            default: b[i] = rand_word();
          endcase
        end
      end
      default: begin
        for (int i = 0; i < NumWords; i++) b[i] = rand_word();
      end
    endcase
    return b;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_block(rand_block());
    drain_results();
  endtask

  initial begin
    blk_t patterns[$];
    blk_t b;
    rst_n         <= 1'b0;
    word_in.valid <= 1'b0;
    drive_words('0);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, single full words, bit patterns, counter-mode blocks
    patterns.push_back('0);
    patterns.push_back('1);
    for (int i = 0; i < NumWords; i++) begin
      b    = '0;
      b[i] = '1;
      patterns.push_back(b);
    end
    for (int i = 0; i < NumWords; i++) b[i] = 64'hAAAA_AAAA_AAAA_AAAA;
    patterns.push_back(b);
    for (int i = 0; i < NumWords; i++) b[i] = 64'h5555_5555_5555_5555;
    patterns.push_back(b);
    for (int i = 0; i < NumWords; i++) b[i] = 64'h8000_0000_0000_0000;
    patterns.push_back(b);
    for (int i = 0; i < NumWords; i++) b[i] = 64'd1;
    patterns.push_back(b);
    for (int i = 0; i < NumWords; i++) b[i] = word_t'(i);
    patterns.push_back(b);
    b = '0; b[1] = 64'd1;
    patterns.push_back(b);
    b[0] = 64'd1;
    patterns.push_back(b);
    b[0] = 64'h0000_0001_0000_0000;
    patterns.push_back(b);
    b[0] = '1;
    patterns.push_back(b);
    foreach (patterns[i]) send_block(patterns[i]);
    drain_results();

    // Long receiver hold-off while the sender keeps pushing: fills the pipe
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    repeat (40) send_block(rand_block());
    drain_results();

    run_phase(110, 0, 0);
    run_phase(110, 59, 0);
    run_phase(110, 0, 59);
    run_phase(120, 23, 23);

    repeat (PipeDepth + 8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("** arx_512bit_mixing_permutation: PASSED **");
    end else begin
      $display("** arx_512bit_mixing_permutation: FAILED **");
    end
    $finish;
  end

endmodule
